@@ src/msp_pkg.sv @@
// shared types, constants and functions of the haploid snp posterior block
`default_nettype none
package msp_pkg;

    localparam int NUM_GT     = 4;
    localparam int PROB_BITS  = 16;
    localparam int SUM_W      = 40;
    localparam int MAG_W      = 21;
    localparam int MANT_W     = 31;
    localparam int W_W        = 31;
    localparam int TOT_W      = 33;
    localparam int Y_W        = 22;
    localparam int NUM_W      = W_W + 16;
    localparam int REM_W      = TOT_W + 1;
    localparam int POST_W     = 17;
    localparam int SQ_STEPS   = 16;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = 6;

    localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
    localparam logic [MAG_W-1:0] LN_THIRD  = MAG_W'(72000);
    localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;
    localparam logic [40:0]      EXP_CUT   = 41'd2097152;
    localparam logic [15:0]      THETA_RST = 16'd66;
    localparam logic [W_W-1:0]   ONE_Q30   = W_W'(1 << 30);

    typedef logic [15:0][29:0] pow_tab_t;

    typedef enum logic [1:0] {
        LN_HIT  = 2'd0,
        LN_MISS = 2'd1,
        LN_PREF = 2'd2,
        LN_PALT = 2'd3
    } ln_sel_t;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_LN_HIT   = 16'h0002,
        ST_LN_MISS  = 16'h0004,
        ST_ACC      = 16'h0008,
        ST_DEC      = 16'h0010,
        ST_PR_REF   = 16'h0020,
        ST_PR_ALT   = 16'h0040,
        ST_SCORE    = 16'h0080,
        ST_SORT     = 16'h0100,
        ST_WT_INIT  = 16'h0200,
        ST_WT_STEP  = 16'h0400,
        ST_WT_FIN   = 16'h0800,
        ST_DIV_INIT = 16'h1000,
        ST_DIV_STEP = 16'h2000,
        ST_DIV_FIN  = 16'h4000,
        ST_EMIT     = 16'h8000
    } state_t;

    typedef struct packed {
        logic    load;
        logic    ln_start;
        ln_sel_t ln_sel;
        logic    acc;
        logic    score;
        logic    sort;
        logic    wt_init;
        logic    wt_step;
        logic    wt_fin;
        logic    div_init;
        logic    div_step;
        logic    div_fin;
        logic    emit;
        logic [1:0] gt;
        logic [3:0] idx;
    } msp_cmd_t;

    typedef struct packed {
        logic ln_done;
        logic has_call;
        logic last;
        logic skip;
    } msp_stat_t;

    function automatic logic [3:0] msb_idx(input logic [15:0] x);
        logic [3:0] k;
        k = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) k = 4'(i);
        end
        return k;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sub(input logic signed [SUM_W-1:0] s,
                                                         input logic [MAG_W-1:0] mag);
        logic [SUM_W:0] diff;
        diff = {s[SUM_W-1], s} - {{(SUM_W+1-MAG_W){1'b0}}, mag};
        if (diff[SUM_W] != diff[SUM_W-1]) return {1'b1, {(SUM_W-1){1'b0}}};
        return diff[SUM_W-1:0];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] v;
        r = 64'd0;
        v = n;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // q0.30 constants 2^-(2^-(i+1))
    function automatic pow_tab_t build_pow();
        pow_tab_t t;
        logic [63:0] p;
        p = isqrt64(64'd1 << 59);
        t[0] = p[29:0];
        for (int i = 1; i < 16; i++) begin
            p = isqrt64(p << 30);
            t[i] = p[29:0];
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow();

endpackage
`default_nettype wire

@@ src/monoploid_snp_posterior_top.sv @@
// top level of the haploid snp genotype posterior block
`default_nettype none
// One position is a run of call beats closed by a beat with last_call set. A beat is taken
// when start is high and busy is low; the block works on one beat at a time. A beat with a
// call runs two logs of 16 squaring steps each on the shared log unit; a beat without a call
// runs none. The closing beat adds two prior logs, four weights of 16 multiply steps each,
// and four 47-step bit-serial divides for the normalized posteriors. A closing beat of a
// skipped position (reference N or no alternate call) skips these. Each result shows for one
// cycle with done high and cannot be stalled. Theta is written through cfg_valid/cfg_ready
// while busy is low.
module monoploid_snp_posterior_top
    import msp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command side
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         ref_base,
    input  wire logic               has_call,
    input  wire logic [1:0]         call_base,
    input  wire logic [15:0]        call_err,
    input  wire logic               last_call,
    // theta write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,
    // result beat
    output logic                    done,
    output logic                    called,
    output logic                    is_snp,
    output logic [1:0]              best_genotype,
    output logic [1:0]              second_genotype,
    output logic [POST_W-1:0]       posterior_gt0,
    output logic [POST_W-1:0]       posterior_gt1,
    output logic [POST_W-1:0]       posterior_gt2,
    output logic [POST_W-1:0]       posterior_gt3
);

    msp_cmd_t  cmd;
    msp_stat_t stat;
    logic      busy_i;

    // theta only changes between beats
    assign cfg_ready = !busy_i;
    assign busy      = busy_i;

    msp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy_i),
        .cmd   (cmd)
    );

    msp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .ref_base        (ref_base),
        .has_call        (has_call),
        .call_base       (call_base),
        .call_err        (call_err),
        .last_call       (last_call),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .called          (called),
        .is_snp          (is_snp),
        .best_genotype   (best_genotype),
        .second_genotype (second_genotype),
        .posterior_gt0   (posterior_gt0),
        .posterior_gt1   (posterior_gt1),
        .posterior_gt2   (posterior_gt2),
        .posterior_gt3   (posterior_gt3)
    );

endmodule
`default_nettype wire

@@ src/msp_ln.sv @@
// shared natural log magnitude unit, one squaring step a cycle
`default_nettype none
module msp_ln
    import msp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [15:0]      x,
    output logic                  done,
    output logic [MAG_W-1:0]      mag
);

    logic              busy_reg, busy_next;
    logic [4:0]        it_reg, it_next;
    logic              done_reg, done_next;
    logic [MANT_W-1:0] m_reg, m_next;
    logic [15:0]       f_reg, f_next;
    logic [3:0]        k_reg, k_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;

    logic [61:0]       sq;
    logic [31:0]       sq_sh;
    logic [20:0]       l2;
    logic [52:0]       prod;
    logic [3:0]        k_in;

    always_comb
    begin
        sq    = {31'd0, m_reg} * {31'd0, m_reg};
        sq_sh = sq[61:30];
        l2    = 21'(PROB_BITS << 16) - {1'b0, k_reg, f_reg};
        prod  = {32'd0, l2} * {21'd0, LN2_Q32} + 53'(64'd1 << 31);
        k_in  = msb_idx(x);

        busy_next = busy_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        m_next    = m_reg;
        f_next    = f_reg;
        k_next    = k_reg;
        mag_next  = mag_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                it_next   = 5'd0;
                k_next    = k_in;
                f_next    = 16'd0;
                m_next    = MANT_W'(x) << (5'd30 - {1'b0, k_in});
            end
        end else if (it_reg != 5'(SQ_STEPS)) begin
            it_next = it_reg + 5'd1;
            if (sq_sh[31]) begin
                m_next = sq_sh[31:1];
                f_next = {f_reg[14:0], 1'b1};
            end else begin
                m_next = sq_sh[30:0];
                f_next = {f_reg[14:0], 1'b0};
            end
        end else begin
            busy_next = 1'b0;
            done_next = 1'b1;
            mag_next  = prod[52:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        f_reg   <= f_next;
        k_reg   <= k_next;
        mag_reg <= mag_next;
    end

    assign done = done_reg;
    assign mag  = mag_reg;

endmodule
`default_nettype wire

@@ src/msp_ctrl.sv @@
// sequencing state machine of the posterior block
`default_nettype none
module msp_ctrl
    import msp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire msp_stat_t stat,
    output logic           busy,
    output msp_cmd_t       cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        gt_reg, gt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        gt_next    = gt_reg;
        cmd        = '0;
        cmd.gt     = gt_reg;
        cmd.idx    = cnt_reg[3:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_LN_HIT;
                end
            end
            ST_LN_HIT, ST_LN_MISS, ST_PR_REF, ST_PR_ALT:
            begin
                case (state_reg)
                    ST_LN_HIT:  cmd.ln_sel = LN_HIT;
                    ST_LN_MISS: cmd.ln_sel = LN_MISS;
                    ST_PR_REF:  cmd.ln_sel = LN_PREF;
                    default:    cmd.ln_sel = LN_PALT;
                endcase
                if (state_reg == ST_LN_HIT && !stat.has_call) begin
                    state_next = ST_ACC;
                end else if (cnt_reg == '0) begin
                    cmd.ln_start = 1'b1;
                    cnt_next     = CNT_W'(1);
                end else if (stat.ln_done) begin
                    cnt_next = '0;
                    case (state_reg)
                        ST_LN_HIT:  state_next = ST_LN_MISS;
                        ST_LN_MISS: state_next = ST_ACC;
                        ST_PR_REF:  state_next = ST_PR_ALT;
                        default:    state_next = ST_SCORE;
                    endcase
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.last ? ST_DEC : ST_IDLE;
            end
            ST_DEC:
            begin
                state_next = stat.skip ? ST_EMIT : ST_PR_REF;
            end
            ST_SCORE:
            begin
                cmd.score  = 1'b1;
                cnt_next   = CNT_W'(1);
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                cmd.sort = 1'b1;
                cmd.gt   = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(NUM_GT - 1)) begin
                    cnt_next   = '0;
                    gt_next    = '0;
                    state_next = ST_WT_INIT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_WT_INIT:
            begin
                cmd.wt_init = 1'b1;
                cnt_next    = '0;
                state_next  = ST_WT_STEP;
            end
            ST_WT_STEP:
            begin
                cmd.wt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1)) begin
                    state_next = ST_WT_FIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_WT_FIN:
            begin
                cmd.wt_fin = 1'b1;
                if (gt_reg == 2'(NUM_GT - 1)) begin
                    gt_next    = '0;
                    state_next = ST_DIV_INIT;
                end else begin
                    gt_next    = gt_reg + 2'd1;
                    state_next = ST_WT_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DIV_FIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV_FIN:
            begin
                cmd.div_fin = 1'b1;
                if (gt_reg == 2'(NUM_GT - 1)) begin
                    state_next = ST_EMIT;
                end else begin
                    gt_next    = gt_reg + 2'd1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            gt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            gt_reg    <= gt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef ASSERT_OFF
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy)
        else $error("accepted beat did not make the block busy");
    a_ln_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.ln_done |-> (state_reg == ST_LN_HIT || state_reg == ST_LN_MISS ||
                          state_reg == ST_PR_REF || state_reg == ST_PR_ALT))
        else $error("log unit finished outside a log step");
`endif

endmodule
`default_nettype wire

@@ src/msp_dp.sv @@
// datapath: likelihood sums, prior, ranking, weights and normalizing divider
`default_nettype none
module msp_dp
    import msp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msp_cmd_t         cmd,
    output msp_stat_t             stat,
    input  wire logic [2:0]       ref_base,
    input  wire logic             has_call,
    input  wire logic [1:0]       call_base,
    input  wire logic [15:0]      call_err,
    input  wire logic             last_call,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_data,
    output logic                  done,
    output logic                  called,
    output logic                  is_snp,
    output logic [1:0]            best_genotype,
    output logic [1:0]            second_genotype,
    output logic [POST_W-1:0]     posterior_gt0,
    output logic [POST_W-1:0]     posterior_gt1,
    output logic [POST_W-1:0]     posterior_gt2,
    output logic [POST_W-1:0]     posterior_gt3
);

    // control state
    logic [15:0]  theta_reg;
    logic         mid_reg;
    logic         saw_reg;
    logic [2:0]   ref_id_reg;
    logic         done_reg;

    // payload
    logic                    has_reg, last_reg;
    logic [1:0]              obs_reg;
    logic [15:0]             e_reg;
    logic [MAG_W-1:0]        hit_reg, miss_reg, pref_reg, palt_reg;
    logic signed [SUM_W-1:0] sums_reg [NUM_GT];
    logic signed [SUM_W-1:0] best_sc_reg, second_sc_reg;
    logic [1:0]              best_reg, second_reg;
    logic [Y_W-1:0]          y_reg;
    logic                    wz_reg;
    logic [W_W-1:0]          w_reg;
    logic [W_W-1:0]          wgt_reg [NUM_GT];
    logic [TOT_W-1:0]        tot_reg;
    logic [NUM_W-1:0]        n_reg;
    logic [TOT_W-1:0]        rem_reg;
    logic [POST_W-1:0]       post_reg [NUM_GT];
    logic                    called_reg, snp_reg;
    logic [1:0]              bo_reg, so_reg;
    logic [POST_W-1:0]       po_reg [NUM_GT];

    logic                    ln_done;
    logic [MAG_W-1:0]        ln_mag;
    logic [15:0]             ln_x;
    logic [15:0]             th_c, e_in;
    logic                    skip;
    logic signed [SUM_W-1:0] v;
    logic [40:0]             d;
    logic [51:0]             yprod;
    logic [60:0]             wprod;
    logic [5:0]              ip;
    logic [W_W-1:0]          wv;
    logic [REM_W-1:0]        r;
    logic [REM_W-1:0]        r_sub;

    msp_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.ln_start),
        .x     (ln_x),
        .done  (ln_done),
        .mag   (ln_mag)
    );

    always_comb
    begin
        th_c  = (theta_reg == 16'd0) ? 16'd1 : theta_reg;
        e_in  = (call_err == 16'd0) ? 16'd1 : call_err;
        case (cmd.ln_sel)
            LN_HIT:  ln_x = 16'd0 - e_reg;
            LN_MISS: ln_x = e_reg;
            LN_PREF: ln_x = 16'd0 - th_c;
            default: ln_x = th_c;
        endcase
        skip  = ref_id_reg[2] || !saw_reg;
        v     = sums_reg[cmd.gt];
        d     = {best_sc_reg[SUM_W-1], best_sc_reg} - {v[SUM_W-1], v};
        yprod = {31'd0, d[20:0]} * {21'd0, LOG2E_Q30} + 52'(64'd1 << 29);
        wprod = {30'd0, w_reg} * {31'd0, POW_TAB[cmd.idx]};
        ip    = y_reg[Y_W-1:16];
        wv    = (wz_reg || ip >= 6'd31) ? '0 : (w_reg >> ip);
        r     = {rem_reg, n_reg[NUM_W-1]};
        r_sub = r - {1'b0, tot_reg};
    end

    assign stat = {ln_done, has_reg, last_reg, skip};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            theta_reg  <= THETA_RST;
            mid_reg    <= 1'b0;
            saw_reg    <= 1'b0;
            ref_id_reg <= 3'd0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= cmd.emit;
            if (cfg_we) theta_reg <= cfg_data;
            if (cmd.load && !mid_reg) begin
                mid_reg    <= 1'b1;
                saw_reg    <= 1'b0;
                ref_id_reg <= ref_base;
            end
            if (cmd.acc) begin
                if (has_reg && ({1'b0, obs_reg} != ref_id_reg)) saw_reg <= 1'b1;
                if (last_reg) mid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            has_reg  <= has_call;
            obs_reg  <= call_base;
            e_reg    <= e_in;
            last_reg <= last_call;
            if (!mid_reg) begin
                for (int g = 0; g < NUM_GT; g++) sums_reg[g] <= '0;
            end
        end
        if (ln_done) begin
            case (cmd.ln_sel)
                LN_HIT:  hit_reg  <= ln_mag;
                LN_MISS: miss_reg <= ln_mag + LN_THIRD;
                LN_PREF: pref_reg <= ln_mag;
                default: palt_reg <= ln_mag + LN_THIRD;
            endcase
        end
        if (cmd.acc && has_reg) begin
            for (int g = 0; g < NUM_GT; g++) begin
                sums_reg[g] <= sat_sub(sums_reg[g], (obs_reg == 2'(g)) ? hit_reg : miss_reg);
            end
        end
        if (cmd.score) begin
            for (int g = 0; g < NUM_GT; g++) begin
                sums_reg[g] <= sat_sub(sums_reg[g],
                                       (ref_id_reg == 3'(g)) ? pref_reg : palt_reg);
            end
            best_sc_reg   <= sat_sub(sums_reg[0], (ref_id_reg == 3'd0) ? pref_reg : palt_reg);
            second_sc_reg <= sat_sub(sums_reg[1], (ref_id_reg == 3'd1) ? pref_reg : palt_reg);
            best_reg      <= 2'd0;
            second_reg    <= 2'd1;
            tot_reg       <= '0;
        end
        if (cmd.sort) begin
            if (v > best_sc_reg) begin
                second_reg    <= best_reg;
                second_sc_reg <= best_sc_reg;
                best_reg      <= cmd.gt;
                best_sc_reg   <= v;
            end else if (v > second_sc_reg) begin
                second_reg    <= cmd.gt;
                second_sc_reg <= v;
            end
        end
        if (cmd.wt_init) begin
            wz_reg <= (d >= EXP_CUT);
            y_reg  <= yprod[51:30];
            w_reg  <= ONE_Q30;
        end
        if (cmd.wt_step && y_reg[4'd15 - cmd.idx]) begin
            w_reg <= wprod[60:30];
        end
        if (cmd.wt_fin) begin
            wgt_reg[cmd.gt] <= wv;
            tot_reg         <= tot_reg + TOT_W'(wv);
        end
        if (cmd.div_init) begin
            n_reg   <= {wgt_reg[cmd.gt], 16'd0} + NUM_W'(tot_reg >> 1);
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!r_sub[REM_W-1]) begin
                rem_reg <= r_sub[TOT_W-1:0];
                n_reg   <= {n_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= r[TOT_W-1:0];
                n_reg   <= {n_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.div_fin) begin
            post_reg[cmd.gt] <= n_reg[POST_W-1:0];
        end
        if (cmd.emit) begin
            called_reg <= !skip;
            snp_reg    <= !skip && (best_reg != ref_id_reg[1:0]);
            bo_reg     <= skip ? 2'd0 : best_reg;
            so_reg     <= skip ? 2'd0 : second_reg;
            for (int g = 0; g < NUM_GT; g++) po_reg[g] <= skip ? '0 : post_reg[g];
        end
    end

    assign done            = done_reg;
    assign called          = called_reg;
    assign is_snp          = snp_reg;
    assign best_genotype   = bo_reg;
    assign second_genotype = so_reg;
    assign posterior_gt0   = po_reg[0];
    assign posterior_gt1   = po_reg[1];
    assign posterior_gt2   = po_reg[2];
    assign posterior_gt3   = po_reg[3];

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result beat held longer than one cycle");
    a_tot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (tot_reg != '0))
        else $error("normalizing divide with zero weight total");
`endif

endmodule
`default_nettype wire
